/* src/lsg_pkg.sv */
// Shared types, constants and helper functions of the lens shading grid gain unit.
`default_nettype none

package lsg_pkg;

  localparam int GRID_ROWS  = 31;
  localparam int GRID_COLS  = 32;
  localparam int TABLE_SIZE = GRID_ROWS * GRID_COLS;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);

  localparam int GAIN_W  = 14;
  localparam int PIX_W   = 16;
  localparam int PIX14_W = 14;
  localparam int STEP_W  = 16;
  localparam int TY_W    = 24;
  localparam int GS_W    = 24;
  localparam int PROD_W  = 40;
  localparam int PP_W    = 36;

  localparam logic [STEP_W-1:0]  STEP_ONE   = 16'h8000;
  localparam logic [PROD_W-1:0]  FRAC_ROUND = 40'd16383;
  localparam logic [PP_W:0]      GAIN_ROUND = 37'd512;
  localparam logic [PIX14_W-1:0] PIX_MAX    = 14'd16383;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BYPASS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL_BLK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL_OFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW_BLK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW_OFF = 3'd6;

  typedef struct packed {
    logic       bypass_enable;
    logic [7:0] block_width;
    logic [7:0] block_height;
    logic [5:0] start_col_block;
    logic [7:0] start_col_offset;
    logic [4:0] start_row_block;
    logic [7:0] start_row_offset;
  } lsg_cfg_t;

  typedef struct packed {
    logic take;
    logic rd_top;
    logic rd_bot;
    logic mul_top;
    logic mul_bot;
    logic blend_bot;
    logic mul_y;
    logic blend_y;
    logic mul_pix;
    logic out_load;
  } lsg_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic in_valid;
    logic in_is_pixel;
    logic bypass;
    logic out_free;
  } lsg_sts_t;

  function automatic logic [4:0] clamp_row(input logic [5:0] b);
    return (b > 6'(GRID_ROWS - 2)) ? 5'(GRID_ROWS - 2) : b[4:0];
  endfunction

  function automatic logic [5:0] clamp_col(input logic [6:0] b);
    return (b > 7'(GRID_COLS - 2)) ? 6'(GRID_COLS - 2) : b[5:0];
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [4:0] r, input logic [6:0] c);
    return TBL_AW'(int'(r) * GRID_COLS + int'(c));
  endfunction

  function automatic logic signed [GS_W-1:0] blend_add(input logic signed [GS_W-1:0] a,
                                                       input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] sh;
    s  = p + $signed(FRAC_ROUND);
    sh = s >>> 15;
    return a + sh[GS_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/lsg_if.sv */
// Valid/ready channel interfaces for the input and result items.
`default_nettype none

interface lsg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [9:0]  gain_index;
  logic [13:0] gain_value;
  logic [15:0] pixel_in;
  logic        line_start;
  logic        frame_start;

  modport source (output valid, action, gain_index, gain_value, pixel_in, line_start,
                  frame_start, input ready);
  modport sink (input valid, action, gain_index, gain_value, pixel_in, line_start,
                frame_start, output ready);
endinterface

interface lsg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

`default_nettype wire

/* src/lsg_recip.sv */
// Bit-serial reciprocal unit that derives both grid step fractions from the block sizes.
`default_nettype none

module lsg_recip import lsg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              recalc_i,
  input  wire logic [7:0]        width_i,
  input  wire logic [7:0]        height_i,
  output logic      [STEP_W-1:0] xstep_o,
  output logic      [STEP_W-1:0] ystep_o,
  output logic                   ready_o
);

  localparam int CNT_W = $clog2(STEP_W);

  logic              dirty_q, busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STEP_W-1:0] num_q, qx_q, qy_q, xstep_q, ystep_q;
  logic [7:0]        rx_q, ry_q, dx_q, dy_q;
  logic [8:0]        tx, ty, nx, ny;
  logic              gex, gey;

  always_comb begin
    tx  = {rx_q, num_q[STEP_W-1]};
    ty  = {ry_q, num_q[STEP_W-1]};
    gex = tx >= {1'b0, dx_q};
    gey = ty >= {1'b0, dy_q};
    nx  = gex ? tx - {1'b0, dx_q} : tx;
    ny  = gey ? ty - {1'b0, dy_q} : ty;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b1;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEP_W - 1)) begin
          busy_q <= 1'b0;
        end
      end else if (dirty_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
      if (recalc_i) begin
        dirty_q <= 1'b1;
      end else if (!busy_q && dirty_q) begin
        dirty_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      num_q <= {num_q[STEP_W-2:0], 1'b0};
      qx_q  <= {qx_q[STEP_W-2:0], gex};
      qy_q  <= {qy_q[STEP_W-2:0], gey};
      rx_q  <= nx[7:0];
      ry_q  <= ny[7:0];
      if (cnt_q == CNT_W'(STEP_W - 1)) begin
        xstep_q <= (dx_q == '0) ? '0 : {qx_q[STEP_W-2:0], gex};
        ystep_q <= (dy_q == '0) ? '0 : {qy_q[STEP_W-2:0], gey};
      end
    end else if (dirty_q) begin
      num_q <= STEP_ONE;
      qx_q  <= '0;
      qy_q  <= '0;
      rx_q  <= '0;
      ry_q  <= '0;
      dx_q  <= width_i;
      dy_q  <= height_i;
    end
  end

  assign xstep_o = xstep_q;
  assign ystep_o = ystep_q;
  assign ready_o = !dirty_q && !busy_q;

endmodule

`default_nettype wire

/* src/lsg_ctrl.sv */
// Controller state machine that sequences table reads, blends and the output load.
`default_nettype none

module lsg_ctrl import lsg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire lsg_sts_t sts_i,
  output logic          in_ready_o,
  output lsg_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDT, S_RDB, S_MT, S_MB, S_GB, S_MY, S_GY, S_MP, S_OUT
  } state_e;

  state_e state_q;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.step_ok;
  assign take       = in_ready_o && sts_i.in_valid;

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = take;
    cmd_o.rd_top    = (state_q == S_RDT);
    cmd_o.rd_bot    = (state_q == S_RDB);
    cmd_o.mul_top   = (state_q == S_MT);
    cmd_o.mul_bot   = (state_q == S_MB);
    cmd_o.blend_bot = (state_q == S_GB);
    cmd_o.mul_y     = (state_q == S_MY);
    cmd_o.blend_y   = (state_q == S_GY);
    cmd_o.mul_pix   = (state_q == S_MP);
    cmd_o.out_load  = (state_q == S_OUT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take && sts_i.in_is_pixel) begin
            state_q <= sts_i.bypass ? S_OUT : S_RDT;
          end
        end
        S_RDT: state_q <= S_RDB;
        S_RDB: state_q <= S_MT;
        S_MT:  state_q <= S_MB;
        S_MB:  state_q <= S_GB;
        S_GB:  state_q <= S_MY;
        S_MY:  state_q <= S_GY;
        S_GY:  state_q <= S_MP;
        S_MP:  state_q <= S_OUT;
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/lsg_datapath.sv */
// Datapath: grid position tracking, gain table, bilinear blend, scaling and result register.
`default_nettype none

module lsg_datapath import lsg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lsg_cfg_t          cfg_i,
  input  wire logic              recalc_i,
  input  wire lsg_cmd_t          cmd_i,
  output lsg_sts_t               sts_o,
  input  wire logic              in_valid_i,
  input  wire logic              action_i,
  input  wire logic [9:0]        gain_index_i,
  input  wire logic [GAIN_W-1:0] gain_value_i,
  input  wire logic [PIX_W-1:0]  pixel_in_i,
  input  wire logic              line_start_i,
  input  wire logic              frame_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [PIX_W-1:0]  pixel_out_o
);

  logic [STEP_W-1:0] xstep, ystep;
  logic              step_ok;

  lsg_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .recalc_i (recalc_i),
    .width_i  (cfg_i.block_width),
    .height_i (cfg_i.block_height),
    .xstep_o  (xstep),
    .ystep_o  (ystep),
    .ready_o  (step_ok)
  );

  logic [4:0] row_block_q, rb_d;
  logic [7:0] row_offset_q, ro_d;
  logic [5:0] col_block_q, cb_d;
  logic [7:0] col_offset_q, co_d;
  logic [7:0] co_use_q;

  always_comb begin
    rb_d = row_block_q;
    ro_d = row_offset_q;
    cb_d = col_block_q;
    co_d = col_offset_q;
    if (frame_start_i) begin
      rb_d = clamp_row({1'b0, cfg_i.start_row_block});
      ro_d = cfg_i.start_row_offset;
    end else if (line_start_i) begin
      ro_d = row_offset_q + 1'b1;
    end
    if (line_start_i || frame_start_i) begin
      cb_d = clamp_col({1'b0, cfg_i.start_col_block});
      co_d = cfg_i.start_col_offset;
      if (ro_d >= cfg_i.block_height) begin
        rb_d = clamp_row({1'b0, rb_d} + 6'd1);
        ro_d = '0;
      end
    end
    if (co_d >= cfg_i.block_width) begin
      cb_d = clamp_col({1'b0, cb_d} + 7'd1);
      co_d = '0;
    end
  end

  logic take_pix, take_wr;
  assign take_pix = cmd_i.take && action_i;
  assign take_wr  = cmd_i.take && !action_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_block_q  <= '0;
      row_offset_q <= '0;
      col_block_q  <= '0;
      col_offset_q <= '0;
    end else if (take_pix) begin
      row_block_q  <= rb_d;
      row_offset_q <= ro_d;
      col_block_q  <= cb_d;
      col_offset_q <= co_d + 1'b1;
    end
  end

  logic [GAIN_W-1:0] mem [TABLE_SIZE];
  logic [GAIN_W-1:0] rda_q, rdb_q;
  logic [TBL_AW-1:0] addr_a, addr_b;
  logic [4:0]        rd_row;

  assign rd_row = cmd_i.rd_bot ? row_block_q + 1'b1 : row_block_q;
  assign addr_a = tbl_addr(rd_row, {1'b0, col_block_q});
  assign addr_b = tbl_addr(rd_row, {1'b0, col_block_q} + 7'd1);

  always_ff @(posedge clk_i) begin
    if (take_wr && (gain_index_i < 10'(TABLE_SIZE))) begin
      mem[gain_index_i[TBL_AW-1:0]] <= gain_value_i;
    end
    if (cmd_i.rd_top || cmd_i.rd_bot) begin
      rda_q <= mem[addr_a];
      rdb_q <= mem[addr_b];
    end
  end

  logic [PIX14_W-1:0]      pix_q;
  logic [STEP_W-1:0]       tx_q;
  logic [TY_W-1:0]         ty_q;
  logic [GAIN_W-1:0]       t0_q, t1_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [GS_W-1:0]  g0_q, g1_q, gain_q;
  logic [PP_W-1:0]         pp_q;
  logic signed [GS_W-1:0]  d_top, d_bot, d_y, gy;
  logic [23:0]             tx_full, ty_full;
  logic [PP_W:0]           pp_rnd;
  logic [PP_W-10:0]        pp_sh;
  logic [PIX14_W-1:0]      pix_res;

  assign d_top   = GS_W'($signed({1'b0, t1_q})) - GS_W'($signed({1'b0, t0_q}));
  assign d_bot   = GS_W'($signed({1'b0, rdb_q})) - GS_W'($signed({1'b0, rda_q}));
  assign d_y     = g1_q - g0_q;
  assign gy      = blend_add(g0_q, prod_q);
  assign tx_full = co_use_q * xstep;
  assign ty_full = row_offset_q * ystep;
  assign pp_rnd  = {1'b0, pp_q} + GAIN_ROUND;
  assign pp_sh   = pp_rnd[PP_W:10];
  assign pix_res = (pp_sh > (PP_W-9)'(PIX_MAX)) ? PIX_MAX : pp_sh[PIX14_W-1:0];

  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      pix_q    <= pixel_in_i[PIX_W-1:PIX_W-PIX14_W];
      co_use_q <= co_d;
    end
    if (cmd_i.rd_top) begin
      tx_q <= tx_full[STEP_W-1:0];
      ty_q <= ty_full;
    end
    if (cmd_i.rd_bot) begin
      t0_q <= rda_q;
      t1_q <= rdb_q;
    end
    if (cmd_i.mul_top) begin
      prod_q <= PROD_W'(d_top * $signed({1'b0, tx_q}));
    end
    if (cmd_i.mul_bot) begin
      g0_q   <= blend_add(GS_W'($signed({1'b0, t0_q})), prod_q);
      prod_q <= PROD_W'(d_bot * $signed({1'b0, tx_q}));
    end
    if (cmd_i.blend_bot) begin
      g1_q <= blend_add(GS_W'($signed({1'b0, rda_q})), prod_q);
    end
    if (cmd_i.mul_y) begin
      prod_q <= PROD_W'(d_y * $signed({1'b0, ty_q}));
    end
    if (cmd_i.blend_y) begin
      gain_q <= gy[GS_W-1] ? '0 : gy;
    end
    if (cmd_i.mul_pix) begin
      pp_q <= PP_W'(pix_q * gain_q[GS_W-2:0]);
    end
  end

  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_out_q <= cfg_i.bypass_enable ? {pix_q, 2'b00} : {pix_res, 2'b00};
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;

  always_comb begin
    sts_o             = '0;
    sts_o.step_ok     = step_ok;
    sts_o.in_valid    = in_valid_i;
    sts_o.in_is_pixel = action_i;
    sts_o.bypass      = cfg_i.bypass_enable;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

/* src/lens_shading_grid_gain_unit.sv */
// Top level of the lens shading grid gain unit: configuration registers and module wiring.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    action, gain_index, gain_value, pixel_in, line/frame start
//   out_o    out  valid/ready    pixel_out
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A table write item is taken while the controller stays idle; a pixel passes through the two
// dual-port reads of the gain table, the serial multiply and blend chain and the output load.
// A bypassed pixel goes from idle straight to the output load. After reset, and after a block
// size write, no item is accepted until the step fraction unit has finished its division.
// A stalled result waits in the output register, holding the pixel sequence in its last step.
`default_nettype none

module lens_shading_grid_gain_unit import lsg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lsg_in_if.sink                     in_i,
  lsg_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  lsg_cfg_t cfg_q;
  lsg_cmd_t cmd;
  lsg_sts_t sts;
  logic     recalc;
  logic     in_ready;

  assign recalc = cfg_we_i && ((cfg_idx_i == REG_BLOCK_WIDTH) ||
                               (cfg_idx_i == REG_BLOCK_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass_enable    <= 1'b0;
      cfg_q.block_width      <= 8'd152;
      cfg_q.block_height     <= 8'd136;
      cfg_q.start_col_block  <= '0;
      cfg_q.start_col_offset <= '0;
      cfg_q.start_row_block  <= '0;
      cfg_q.start_row_offset <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BYPASS:        cfg_q.bypass_enable    <= cfg_data_i[0];
        REG_BLOCK_WIDTH:   cfg_q.block_width      <= cfg_data_i;
        REG_BLOCK_HEIGHT:  cfg_q.block_height     <= cfg_data_i;
        REG_START_COL_BLK: cfg_q.start_col_block  <= cfg_data_i[5:0];
        REG_START_COL_OFF: cfg_q.start_col_offset <= cfg_data_i;
        REG_START_ROW_BLK: cfg_q.start_row_block  <= cfg_data_i[4:0];
        REG_START_ROW_OFF: cfg_q.start_row_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  lsg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .recalc_i      (recalc),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_valid_i    (in_i.valid),
    .action_i      (in_i.action),
    .gain_index_i  (in_i.gain_index),
    .gain_value_i  (in_i.gain_value),
    .pixel_in_i    (in_i.pixel_in),
    .line_start_i  (in_i.line_start),
    .frame_start_i (in_i.frame_start),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .pixel_out_o   (out_o.pixel_out)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

/* tb/lsg_scoreboard.sv */
// Checker of the lens shading grid gain unit: predicts each corrected pixel and compares.
`default_nettype none

module lsg_scoreboard import lsg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  lsg_in_if                          in_mon,
  lsg_out_if                         out_mon,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  logic [GAIN_W-1:0] gain_grid [TABLE_SIZE];
  logic [4:0]        row_blk;
  logic [7:0]        row_off;
  logic [5:0]        col_blk;
  logic [7:0]        col_off;
  lsg_cfg_t          cfg;
  logic [15:0]       pixels_due [$];

  function automatic longint mix(longint a, longint b, int off, int stp);
    longint s;
    s = (b - a) * off * stp + 16383;
    return a + (s >>> 15);
  endfunction

  function automatic longint grid_at(int r, int c);
    return longint'(gain_grid[r * GRID_COLS + c]);
  endfunction

  function automatic logic [4:0] row_lim(int b);
    return (b > GRID_ROWS - 2) ? 5'(GRID_ROWS - 2) : 5'(b);
  endfunction

  function automatic logic [5:0] col_lim(int b);
    return (b > GRID_COLS - 2) ? 6'(GRID_COLS - 2) : 6'(b);
  endfunction

  task automatic queue_pixel(input logic [15:0] v);
    pixels_due.insert(pixels_due.size(), v);
  endtask

  task automatic correct_pixel(input logic [15:0] pix, input logic ls, input logic fs);
    int     xs, ys, r, c;
    longint top, bot, g, prod;
    logic [13:0] p14;
    if (fs) begin
      row_blk = row_lim(int'(cfg.start_row_block));
      row_off = cfg.start_row_offset;
    end else if (ls) begin
      row_off = row_off + 8'd1;
    end
    if (ls || fs) begin
      col_blk = col_lim(int'(cfg.start_col_block));
      col_off = cfg.start_col_offset;
      if (row_off >= cfg.block_height) begin
        row_blk = row_lim(int'(row_blk) + 1);
        row_off = '0;
      end
    end
    if (col_off >= cfg.block_width) begin
      col_blk = col_lim(int'(col_blk) + 1);
      col_off = '0;
    end
    p14 = pix[15:2];
    if (cfg.bypass_enable) begin
      queue_pixel({p14, 2'b00});
    end else begin
      xs = (cfg.block_width != 0) ? 32768 / int'(cfg.block_width) : 0;
      ys = (cfg.block_height != 0) ? 32768 / int'(cfg.block_height) : 0;
      r = int'(row_blk);
      c = int'(col_blk);
      top = mix(grid_at(r, c), grid_at(r, c + 1), int'(col_off), xs);
      bot = mix(grid_at(r + 1, c), grid_at(r + 1, c + 1), int'(col_off), xs);
      g = mix(top, bot, int'(row_off), ys);
      if (g < 0) g = 0;
      prod = (longint'(p14) * g + 512) / 1024;
      if (prod > 16383) prod = 16383;
      queue_pixel({prod[13:0], 2'b00});
    end
    col_off = col_off + 8'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      foreach (gain_grid[i]) gain_grid[i] = '0;
      row_blk = '0;
      row_off = '0;
      col_blk = '0;
      col_off = '0;
      cfg = '{bypass_enable: 1'b0, block_width: 8'd152, block_height: 8'd136,
              default: '0};
      pixels_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BYPASS: cfg.bypass_enable = cfg_data_i[0];
          REG_BLOCK_WIDTH: cfg.block_width = cfg_data_i;
          REG_BLOCK_HEIGHT: cfg.block_height = cfg_data_i;
          REG_START_COL_BLK: cfg.start_col_block = cfg_data_i[5:0];
          REG_START_COL_OFF: cfg.start_col_offset = cfg_data_i;
          REG_START_ROW_BLK: cfg.start_row_block = cfg_data_i[4:0];
          REG_START_ROW_OFF: cfg.start_row_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (!in_mon.action) begin
          if (int'(in_mon.gain_index) < TABLE_SIZE) begin
            gain_grid[in_mon.gain_index] = in_mon.gain_value;
          end
        end else begin
          correct_pixel(in_mon.pixel_in, in_mon.line_start, in_mon.frame_start);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel_out, expected none, actual %0d", $time,
                   out_mon.pixel_out);
          fail_count_o++;
        end else begin
          want = pixels_due.pop_front();
          if (out_mon.pixel_out !== want) begin
            $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $time, want,
                     out_mon.pixel_out);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = pixels_due.size();
  end

endmodule

`default_nettype wire

/* tb/tb_lens_shading_grid_gain_unit.sv */
// Testbench top of the lens shading grid gain unit: stimulus, idling and verdict.
`default_nettype none

module tb_lens_shading_grid_gain_unit;
  import lsg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  int                    pixels_sent;

  lsg_in_if  in_ch ();
  lsg_out_if out_ch ();

  lens_shading_grid_gain_unit u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  lsg_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit quiet_window();
    return cycle_count >= 3000 && cycle_count < 6000;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= quiet_window() || $urandom_range(0, 99) >= 18;
  end

  task automatic send(input logic act, input logic [9:0] idx, input logic [13:0] gval,
                      input logic [15:0] pix, input logic ls, input logic fs);
    int gap;
    gap = (!quiet_window() && $urandom_range(0, 99) < 18) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.gain_index  <= idx;
    in_ch.gain_value  <= gval;
    in_ch.pixel_in    <= pix;
    in_ch.line_start  <= ls;
    in_ch.frame_start <= fs;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (act) pixels_sent++;
  endtask

  task automatic write_gain(input logic [9:0] idx, input logic [13:0] gval);
    send(1'b0, idx, gval, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic put_pixel(input logic [15:0] pix, input logic ls, input logic fs);
    send(1'b1, 10'($urandom), 14'($urandom), pix, ls, fs);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic program_grid(input logic byp, input logic [7:0] bw, input logic [7:0] bh,
                              input logic [5:0] scb, input logic [7:0] sco,
                              input logic [4:0] srb, input logic [7:0] sro);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [7:0]           val [7];
    idx = '{REG_BYPASS, REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT, REG_START_COL_BLK,
            REG_START_COL_OFF, REG_START_ROW_BLK, REG_START_ROW_OFF};
    val = '{{7'd0, byp}, bw, bh, {2'd0, scb}, sco, {3'd0, srb}, sro};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Frames of lines with random content, with some table writes and stray marks mixed in.
  task automatic stream_frames(input int count, input int line_max);
    int n, line_len, col, lines_left;
    n = 0;
    line_len = 0;
    col = 0;
    lines_left = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 6) begin
        write_gain(10'($urandom_range(0, 1023)), 14'($urandom));
      end else if ($urandom_range(0, 99) < 5) begin
        put_pixel(16'($urandom), 1'($urandom), 1'($urandom));
      end else if (lines_left == 0) begin
        lines_left = $urandom_range(2, 12);
        line_len = $urandom_range(1, line_max);
        col = 1;
        put_pixel(16'($urandom), 1'($urandom), 1'b1);
      end else if (col >= line_len) begin
        lines_left--;
        col = 1;
        put_pixel(16'($urandom), 1'b1, 1'b0);
      end else begin
        col++;
        put_pixel(16'($urandom), 1'b0, 1'b0);
      end
      n++;
    end
  endtask

  initial begin
    int w;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.gain_index <= '0;
    in_ch.gain_value <= '0;
    in_ch.pixel_in <= '0;
    in_ch.line_start <= 1'b0;
    in_ch.frame_start <= 1'b0;
    pixels_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The whole table is written first, so that no read hits an entry never written.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      write_gain(10'(i), (i % 7 == 0) ? 14'd16383 : (i % 11 == 0) ? 14'd0 : 14'($urandom));
    end
    put_pixel(16'hFFFF, 1'b0, 1'b0);
    put_pixel(16'h0000, 1'b0, 1'b0);
    write_gain(10'd992, 14'd16383);
    write_gain(10'd1023, 14'd0);
    write_gain(10'd991, 14'd16383);
    put_pixel(16'hFFFF, 1'b1, 1'b1);
    put_pixel(16'h8001, 1'b1, 1'b0);
    put_pixel(16'h7FFE, 1'b0, 1'b1);

    program_grid(1'b0, 8'd4, 8'd3, 6'd0, 8'd0, 5'd0, 8'd0);
    stream_frames(80, 14);
    program_grid(1'b0, 8'd1, 8'd1, 6'd63, 8'd255, 5'd31, 8'd255);
    put_pixel(16'hFFFF, 1'b1, 1'b1);
    put_pixel(16'h0003, 1'b1, 1'b0);
    stream_frames(60, 6);
    program_grid(1'b0, 8'd255, 8'd255, 6'd30, 8'd200, 5'd29, 8'd250);
    stream_frames(60, 300);
    program_grid(1'b0, 8'd0, 8'd0, 6'd5, 8'd3, 5'd2, 8'd1);
    stream_frames(40, 8);
    program_grid(1'b1, 8'd2, 8'd2, 6'd1, 8'd0, 5'd1, 8'd0);
    put_pixel(16'hFFFF, 1'b0, 1'b1);
    stream_frames(40, 8);
    for (int ph = 0; ph < 6; ph++) begin
      w = $urandom_range(1, 12);
      program_grid(1'($urandom_range(0, 9) == 0), 8'(w), 8'($urandom_range(1, 8)),
                   6'($urandom_range(0, 33)), 8'($urandom_range(0, 15)),
                   5'($urandom_range(0, 31)), 8'($urandom_range(0, 10)));
      stream_frames(70, 4 * w);
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/lsg_pkg.sv
src/lsg_if.sv
src/lsg_recip.sv
src/lsg_ctrl.sv
src/lsg_datapath.sv
src/lens_shading_grid_gain_unit.sv
tb/lsg_scoreboard.sv
tb/tb_lens_shading_grid_gain_unit.sv
